// ----- rtl/lpod_pkg.sv -----
// Shared types, codes and helper functions for the line program opcode decoder.
// Used by lpod_front, lpod_queue, lpod_back and line_program_opcode_decoder.
`default_nettype none

package lpod_pkg;

   // Record classes on the result channel.
   localparam logic [1:0] CLASS_STD  = 2'd0;
   localparam logic [1:0] CLASS_EXT  = 2'd1;
   localparam logic [1:0] CLASS_SPEC = 2'd2;

   // Standard opcode numbers that carry operands or need special handling.
   localparam logic [7:0] OP_ADVANCE_PC   = 8'd2;
   localparam logic [7:0] OP_ADVANCE_LINE = 8'd3;
   localparam logic [7:0] OP_SET_FILE     = 8'd4;
   localparam logic [7:0] OP_SET_COLUMN   = 8'd5;
   localparam logic [7:0] OP_CONST_STEP   = 8'd8;
   localparam logic [7:0] OP_FIXED_ADV_PC = 8'd9;

   // Extended subtypes.
   localparam logic [7:0] EXT_UNKNOWN      = 8'd0;
   localparam logic [7:0] EXT_END_SEQUENCE = 8'd1;
   localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;
   localparam logic [7:0] EXT_DEFINE_FILE  = 8'd3;
   localparam logic [7:0] EXT_DISCRIM      = 8'd4;

   // Highest opcode byte, used as the dividend source of the constant address step.
   localparam logic [7:0] MAX_OPCODE = 8'd255;
   // Saturation limit of the byte counter.
   localparam logic [8:0] COUNT_MAX  = 9'd511;
   // Configuration register indexes.
   localparam logic [1:0] CSR_MIN_INSTR   = 2'd0;
   localparam logic [1:0] CSR_LINE_OFFSET = 2'd1;
   localparam logic [1:0] CSR_LINE_SPAN   = 2'd2;
   localparam logic [1:0] CSR_OP_BASE     = 2'd3;
   // Queue depth between front and back.
   localparam int QUEUE_DEPTH = 2;
   // Divider iterations, one quotient bit each.
   localparam logic [3:0] DIV_STEPS = 4'd8;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_STD_ULEB,
      PH_STD_SLEB,
      PH_STD_FIX,
      PH_EXT_LEN,
      PH_EXT_SUB,
      PH_EXT_ADDR,
      PH_EXT_NAME,
      PH_EXT_ULEB,
      PH_EXT_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      JOB_PASS,
      JOB_SCALE,
      JOB_SPECIAL,
      JOB_CONST_ADD
   } job_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

   // One classified opcode waiting for the back end.
   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   op_class;
      logic [7:0]   op_code;
      logic [31:0]  addr;
      logic [31:0]  line;
      logic [31:0]  arg;
      logic [31:0]  dir;
      logic [31:0]  ftime;
      logic [31:0]  fsize;
      logic [8:0]   len;
   } job_type;

   typedef struct packed {
      logic [7:0] min_instr_length;
      logic [7:0] line_offset;
      logic [7:0] line_span;
      logic [7:0] first_special;
   } cfg_type;

   typedef struct packed {
      logic [31:0] acc;
      logic [5:0]  sh;
      logic        done;
   } leb_type;

   // One LEB128 byte: bits beyond 32 are dropped, sign extends only below bit 32.
   function automatic leb_type leb_step(logic [31:0] acc, logic [5:0] sh,
                                        logic [7:0] b, logic sgn);
      leb_type r;
      r.acc  = acc;
      r.sh   = sh;
      r.done = ~b[7];
      if (sh < 6'd32) begin
         r.acc = acc | ({25'd0, b[6:0]} << sh);
         r.sh  = sh + 6'd7;
      end
      if (r.done && sgn && b[6] && (r.sh < 6'd32)) begin
         r.acc = r.acc | (32'hFFFF_FFFF << r.sh);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lpod_front.sv -----
// Front end: parses the byte stream and pushes one classified job per opcode.
// Depends on lpod_pkg.
`default_nettype none

module lpod_front
   import lpod_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_take,
   input  wire logic [7:0] in_byte,
   output logic         push,
   output job_type      push_job
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  cur_ff, cur_in;
   logic [7:0]  rem_ff, rem_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  sh_ff, sh_in;
   logic [8:0]  bc_ff, bc_in;
   logic [1:0]  fi_ff, fi_in;
   logic [31:0] h0_ff, h0_in, h1_ff, h1_in, h2_ff, h2_in;

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cur_ff   <= '0;
         rem_ff   <= '0;
         acc_ff   <= '0;
         sh_ff    <= '0;
         bc_ff    <= '0;
         fi_ff    <= '0;
         h0_ff    <= '0;
         h1_ff    <= '0;
         h2_ff    <= '0;
      end else if (in_take) begin
         phase_ff <= phase_in;
         cur_ff   <= cur_in;
         rem_ff   <= rem_in;
         acc_ff   <= acc_in;
         sh_ff    <= sh_in;
         bc_ff    <= bc_in;
         fi_ff    <= fi_in;
         h0_ff    <= h0_in;
         h1_ff    <= h1_in;
         h2_ff    <= h2_in;
      end
   end

   // Next parser state and the job for a completed opcode.
   always_comb begin
      leb_type    lb;
      logic       ext_go;
      logic [8:0] bc_inc;
      phase_in = phase_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      bc_in    = bc_ff;
      fi_in    = fi_ff;
      h0_in    = h0_ff;
      h1_in    = h1_ff;
      h2_in    = h2_ff;
      push     = 1'b0;
      push_job = '0;
      ext_go   = 1'b0;
      bc_inc   = (bc_ff != COUNT_MAX) ? bc_ff + 9'd1 : bc_ff;
      lb       = leb_step(acc_ff, sh_ff, in_byte, phase_ff == PH_STD_SLEB);

      case (phase_ff)
         PH_IDLE: begin
            if (in_byte == 8'd0) begin
               phase_in = PH_EXT_LEN;
               cur_in   = EXT_UNKNOWN;
            end else if (in_byte <= OP_FIXED_ADV_PC) begin
               cur_in = in_byte;
               bc_in  = 9'd1;
               acc_in = '0;
               sh_in  = '0;
               push_job.op_class = CLASS_STD;
               push_job.op_code  = in_byte;
               push_job.len      = 9'd1;
               if (in_byte == OP_ADVANCE_PC || in_byte == OP_SET_FILE ||
                   in_byte == OP_SET_COLUMN) begin
                  phase_in = PH_STD_ULEB;
               end else if (in_byte == OP_ADVANCE_LINE) begin
                  phase_in = PH_STD_SLEB;
               end else if (in_byte == OP_FIXED_ADV_PC) begin
                  phase_in = PH_STD_FIX;
               end else if (in_byte == OP_CONST_STEP) begin
                  push          = 1'b1;
                  push_job.kind = JOB_CONST_ADD;
               end else begin
                  push          = 1'b1;
                  push_job.kind = JOB_PASS;
               end
            end else begin
               push              = 1'b1;
               push_job.kind     = JOB_SPECIAL;
               push_job.op_class = CLASS_SPEC;
               push_job.op_code  = in_byte;
               push_job.len      = 9'd1;
            end
         end
         PH_STD_ULEB, PH_STD_SLEB: begin
            bc_in  = bc_inc;
            acc_in = lb.acc;
            sh_in  = lb.sh;
            if (lb.done) begin
               phase_in          = PH_IDLE;
               push              = 1'b1;
               push_job.op_class = CLASS_STD;
               push_job.op_code  = cur_ff;
               push_job.len      = bc_inc;
               if (phase_ff == PH_STD_SLEB) begin
                  push_job.kind = JOB_PASS;
                  push_job.line = lb.acc;
               end else if (cur_ff == OP_ADVANCE_PC) begin
                  push_job.kind = JOB_SCALE;
                  push_job.addr = lb.acc;
               end else begin
                  push_job.kind = JOB_PASS;
                  push_job.arg  = lb.acc;
               end
            end
         end
         PH_STD_FIX: begin
            bc_in = bc_inc;
            if (sh_ff == 6'd0) begin
               acc_in = {24'd0, in_byte};
               sh_in  = 6'd1;
            end else begin
               phase_in          = PH_IDLE;
               acc_in            = {16'd0, in_byte, acc_ff[7:0]};
               push              = 1'b1;
               push_job.kind     = JOB_SCALE;
               push_job.op_class = CLASS_STD;
               push_job.op_code  = OP_FIXED_ADV_PC;
               push_job.addr     = {16'd0, in_byte, acc_ff[7:0]};
               push_job.len      = 9'd3;
            end
         end
         PH_EXT_LEN: begin
            rem_in = in_byte;
            bc_in  = {1'b0, in_byte} + 9'd2;
            cur_in = EXT_UNKNOWN;
            h0_in  = '0;
            h1_in  = '0;
            h2_in  = '0;
            fi_in  = '0;
            acc_in = '0;
            sh_in  = '0;
            if (in_byte == 8'd0) begin
               // Empty extended op completes at once.
               phase_in          = PH_IDLE;
               push              = 1'b1;
               push_job.kind     = JOB_PASS;
               push_job.op_class = CLASS_EXT;
               push_job.op_code  = EXT_UNKNOWN;
               push_job.len      = 9'd2;
            end else begin
               phase_in = PH_EXT_SUB;
            end
         end
         PH_EXT_SUB: begin
            ext_go = 1'b1;
            cur_in = (in_byte >= EXT_END_SEQUENCE && in_byte <= EXT_DISCRIM) ?
                     in_byte : EXT_UNKNOWN;
            if (in_byte == EXT_SET_ADDRESS) begin
               phase_in = PH_EXT_ADDR;
            end else if (in_byte == EXT_DEFINE_FILE) begin
               phase_in = PH_EXT_NAME;
            end else if (in_byte == EXT_DISCRIM) begin
               phase_in = PH_EXT_ULEB;
            end else begin
               phase_in = PH_EXT_SKIP;
            end
         end
         PH_EXT_ADDR: begin
            ext_go = 1'b1;
            h0_in  = h0_ff | ({24'd0, in_byte} << {sh_ff[1:0], 3'b000});
            sh_in  = sh_ff + 6'd1;
            if (sh_in >= 6'd4) begin
               phase_in = PH_EXT_SKIP;
            end
         end
         PH_EXT_NAME: begin
            ext_go = 1'b1;
            if (in_byte == 8'd0) begin
               phase_in = PH_EXT_ULEB;
            end
         end
         PH_EXT_ULEB: begin
            ext_go = 1'b1;
            acc_in = lb.acc;
            sh_in  = lb.sh;
            if (lb.done) begin
               case (fi_ff)
                  2'd0:    h0_in = lb.acc;
                  2'd1:    h1_in = lb.acc;
                  default: h2_in = lb.acc;
               endcase
               acc_in = '0;
               sh_in  = '0;
               if (cur_ff == EXT_DEFINE_FILE && fi_ff < 2'd2) begin
                  fi_in = fi_ff + 2'd1;
               end else begin
                  phase_in = PH_EXT_SKIP;
               end
            end
         end
         PH_EXT_SKIP: begin
            ext_go = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // Extended payload countdown; the last payload byte closes the record.
      if (ext_go) begin
         rem_in = rem_ff - 8'd1;
         if (rem_in == 8'd0) begin
            if (phase_in == PH_EXT_ULEB) begin
               case (fi_in)
                  2'd0:    h0_in = acc_in;
                  2'd1:    h1_in = acc_in;
                  default: h2_in = acc_in;
               endcase
            end
            phase_in          = PH_IDLE;
            push              = 1'b1;
            push_job.kind     = JOB_PASS;
            push_job.op_class = CLASS_EXT;
            push_job.op_code  = cur_in;
            push_job.len      = bc_ff;
            if (cur_in == EXT_DEFINE_FILE) begin
               push_job.dir   = h0_in;
               push_job.ftime = h1_in;
               push_job.fsize = h2_in;
            end else if (cur_in == EXT_SET_ADDRESS || cur_in == EXT_DISCRIM) begin
               push_job.arg = h0_in;
            end
         end
      end

      // A job leaves the parser only in a cycle that takes a word.
      if (!in_take) begin
         push = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lpod_queue.sv -----
// Two-word queue that decouples the parser from the arithmetic back end.
// Depends on lpod_pkg.
`default_nettype none

module lpod_queue
   import lpod_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_data,
   input  wire logic pop,
   output job_type   pop_data,
   output logic      full,
   output logic      empty
);

   job_type    mem_ff [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, rd_ff;

   assign full     = (count_ff == 2'(QUEUE_DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   // Occupancy follows push and pop.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   // Storage words.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ff == rd_ff) |-> (empty || full))
      else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

// ----- rtl/lpod_back.sv -----
// Back end: divides special and constant address step opcodes by the line span, scales
// address advances and holds the finished record in the output register. Depends on lpod_pkg.
`default_nettype none

module lpod_back
   import lpod_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  cfg_type    cfg,
   input  wire logic  q_empty,
   input  job_type    q_data,
   output logic       q_pop,
   output logic       out_valid,
   input  wire logic  out_stall,
   output job_type    out_rec
);

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [7:0]     quo_ff, quo_in;
   logic [7:0]     rem_ff, rem_in;
   logic [7:0]     div_ff, div_in;
   logic           neg_ff, neg_in;
   logic [3:0]     step_ff, step_in;
   logic           out_valid_ff, out_valid_in;
   job_type        out_ff, out_in;

   assign out_valid = out_valid_ff;
   assign out_rec   = out_ff;

   // Sequencer state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working and output payload registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_data;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      out_ff <= out_in;
   end

   // Take a job, run the restoring divider for special and constant step jobs, then scale and finish the record.
   always_comb begin
      logic [8:0]  adj;
      logic [8:0]  trial;
      logic [8:0]  q_s;
      logic [8:0]  m_s;
      logic [31:0] mul_a;
      logic [39:0] prod;
      state_in     = state_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && out_stall;
      q_pop        = 1'b0;
      adj          = '0;
      trial        = {rem_ff, quo_ff[7]};
      q_s          = neg_ff ? 9'd0 - {1'b0, quo_ff} : {1'b0, quo_ff};
      m_s          = neg_ff ? 9'd0 - {1'b0, rem_ff} : {1'b0, rem_ff};
      mul_a        = (job_ff.kind == JOB_SCALE) ? job_ff.addr : {{23{q_s[8]}}, q_s};
      prod         = mul_a * {32'd0, cfg.min_instr_length};

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               // Signed dividend: opcode byte (MAX_OPCODE for the constant step) minus the first special opcode.
               if (q_data.kind == JOB_CONST_ADD) begin
                  adj = {1'b0, MAX_OPCODE} - {1'b0, cfg.first_special};
               end else begin
                  adj = {1'b0, q_data.op_code} - {1'b0, cfg.first_special};
               end
               neg_in = adj[8];
               div_in = cfg.line_span;
               step_in = '0;
               if (q_data.kind == JOB_SPECIAL || q_data.kind == JOB_CONST_ADD) begin
                  if (cfg.line_span == 8'd0) begin
                     // Zero range: quotient zero, remainder is the dividend.
                     quo_in   = '0;
                     rem_in   = adj[8] ? 8'(9'd0 - adj) : adj[7:0];
                     state_in = BK_DONE;
                  end else begin
                     quo_in   = adj[8] ? 8'(9'd0 - adj) : adj[7:0];
                     rem_in   = '0;
                     state_in = BK_DIV;
                  end
               end else begin
                  state_in = BK_DONE;
               end
            end
         end
         BK_DIV: begin
            // One quotient bit per cycle.
            if (trial >= {1'b0, div_ff}) begin
               rem_in = 8'(trial - {1'b0, div_ff});
               quo_in = {quo_ff[6:0], 1'b1};
            end else begin
               rem_in = trial[7:0];
               quo_in = {quo_ff[6:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_in == DIV_STEPS) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_valid_ff || !out_stall) begin
               out_in       = job_ff;
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
               case (job_ff.kind)
                  JOB_SCALE, JOB_CONST_ADD: begin
                     out_in.addr = prod[31:0];
                  end
                  JOB_SPECIAL: begin
                     out_in.addr = prod[31:0];
                     out_in.line = {{24{cfg.line_offset[7]}}, cfg.line_offset} +
                                   {{23{m_s[8]}}, m_s};
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (step_ff < DIV_STEPS))
      else $error("divider ran past its last step");

   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE))
      else $error("job taken while the back end was busy");

   a_remainder_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ----- rtl/line_program_opcode_decoder.sv -----
// Line-number program opcode decoder, one program byte per word.
// A record passes from the queue word through the back end's job register to the output
// register; special and constant address step ops also run the bit-serial 8-step divider.
// The front takes one byte per cycle into a two-word queue while that queue is not full;
// the back takes a new job only after it has finished the last record.
// Synchronous active-high reset restores the default registers and empties all.
`default_nettype none

module line_program_opcode_decoder
   import lpod_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_op_class,
   output logic [7:0]       rsp_op_code,
   output logic [31:0]      rsp_addr_advance,
   output logic signed [31:0] rsp_line_advance,
   output logic [31:0]      rsp_arg_value,
   output logic [31:0]      rsp_file_dir,
   output logic [31:0]      rsp_file_time,
   output logic [31:0]      rsp_file_size,
   output logic [8:0]       rsp_op_length,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   cfg_type cfg_ff;
   logic    take;
   logic    push, q_full, q_empty, q_pop;
   job_type push_job, q_data, out_rec;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_instr_length <= 8'd1;
         cfg_ff.line_offset      <= 8'hFB;
         cfg_ff.line_span        <= 8'd14;
         cfg_ff.first_special    <= 8'd13;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_INSTR:   cfg_ff.min_instr_length <= csr_wdata;
            CSR_LINE_OFFSET: cfg_ff.line_offset      <= csr_wdata;
            CSR_LINE_SPAN:   cfg_ff.line_span        <= csr_wdata;
            CSR_OP_BASE:     cfg_ff.first_special    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lpod_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_take  (take),
      .in_byte  (req_data_byte),
      .push     (push),
      .push_job (push_job)
   );

   lpod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   lpod_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_rec   (out_rec)
   );

   // Result word fields.
   assign rsp_op_class     = out_rec.op_class;
   assign rsp_op_code      = out_rec.op_code;
   assign rsp_addr_advance = out_rec.addr;
   assign rsp_line_advance = out_rec.line;
   assign rsp_arg_value    = out_rec.arg;
   assign rsp_file_dir     = out_rec.dir;
   assign rsp_file_time    = out_rec.ftime;
   assign rsp_file_size    = out_rec.fsize;
   assign rsp_op_length    = out_rec.len;

endmodule

`default_nettype wire
